@@ hw/rtl/dxt3_pkg.sv @@
// ----------------------------------------------------------------------------
// dxt3_pkg
// Shared types, constants and helper functions of the DXT3 block decoder.
// ----------------------------------------------------------------------------
package dxt3_pkg;

    // field widths
    localparam int unsigned ALPHA_W   = 64;
    localparam int unsigned EP_W      = 16;
    localparam int unsigned INDEX_W   = 32;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned PIX_IDX_W = 24;
    localparam int unsigned WIDTH_W   = 13;
    localparam int unsigned S_DATA_W  = 152;
    localparam int unsigned M_DATA_W  = 56;

    // image width limit and reset value
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 13'd4096;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd256;

    // channel order inside a colour
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // index of the last pixel in a block
    localparam logic [3:0] LAST_PIXEL = 4'd15;

    // interpolation weights, 10 fractional bits
    localparam logic [9:0] W_NEAR = 10'd683;
    localparam logic [9:0] W_FAR  = 10'd341;

    typedef logic [2:0][7:0]  rgb_t;
    typedef logic [2:0][17:0] prod_t;

    // stage 1: endpoints widened to 8 bits
    typedef struct packed {
        rgb_t               c0;
        rgb_t               c1;
        logic [ALPHA_W-1:0] alpha_bits;
        logic [INDEX_W-1:0] index_bits;
        logic [POS_W-1:0]   block_row;
        logic [POS_W-1:0]   block_col;
    } st1_t;

    // stage 2: weighted products and row base
    typedef struct packed {
        rgb_t                 c0;
        rgb_t                 c1;
        prod_t                near0;
        prod_t                far1;
        prod_t                far0;
        prod_t                near1;
        logic [PIX_IDX_W-1:0] row_base;
        logic [ALPHA_W-1:0]   alpha_bits;
        logic [INDEX_W-1:0]   index_bits;
        logic [POS_W-1:0]     block_col;
    } st2_t;

    // stage 3: full four-entry palette
    typedef struct packed {
        logic [3:0][23:0]     palette;
        logic [PIX_IDX_W-1:0] row_base;
        logic [ALPHA_W-1:0]   alpha_bits;
        logic [INDEX_W-1:0]   index_bits;
        logic [POS_W-1:0]     block_col;
    } st3_t;

    // 5-bit channel to 8 bits
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd527 + 14'd23;
        return t[13:6];
    endfunction

    // 6-bit channel to 8 bits
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd259 + 14'd33;
        return t[13:6];
    endfunction

    // weight times channel
    function automatic logic [17:0] weigh(input logic [9:0] w, input logic [7:0] c);
        return 18'(w) * 18'(c);
    endfunction

endpackage

@@ hw/rtl/dxt3_block_decoder_top.sv @@
// ----------------------------------------------------------------------------
// dxt3_block_decoder_top
// DXT3 (BC2) block decoder: one 128-bit block in, sixteen RGBA pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per block: alpha bits, two RGB565 endpoints,
//   index bits and the block row/column. m_* returns sixteen pixel requests
//   per block in raster order, each with its linear pixel index; m_tlast
//   marks the sixteenth pixel. cfg_* writes the image width (saturated to
//   4096); write it only while the decoder is idle.
//   A block passes through the three palette stages, then the serializer
//   and the pixel output register.
//   Throughput: one pixel per cycle while m_tready is high, set by the
//   single pixel output port; the three palette stages buffer up to three
//   further blocks while the serializer is busy.
//   Reset (aresetn low, synchronous) empties all stages, drops any pending
//   pixel and sets the width to 256.
//   When the receiver stalls, the current pixel holds on m_*, the serializer
//   and palette stages fill up, and s_tready drops once all are full.
// ----------------------------------------------------------------------------
module dxt3_block_decoder_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // block input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // alpha_bits[63:0], endpoint_zero[79:64], endpoint_one[95:80],
    // index_bits[127:96], block_row[137:128], block_col[147:138], zero pad
    input  logic [dxt3_pkg::S_DATA_W-1:0]  s_tdata,
    // pixel output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_index[23:0], red[31:24], green[39:32], blue[47:40], alpha[55:48]
    output logic [dxt3_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    // image width write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dxt3_pkg::WIDTH_W-1:0]   cfg_data
);

    logic [dxt3_pkg::WIDTH_W-1:0] width_reg;

    logic            v1_reg, v2_reg, v3_reg;
    dxt3_pkg::st1_t  st1_reg, st1_next;
    dxt3_pkg::st2_t  st2_reg, st2_next;
    dxt3_pkg::st3_t  st3_reg, st3_next;
    logic            free1, free2, free3;

    logic                              ser_v_reg, ser_v_next;
    logic [3:0]                        cnt_reg, cnt_next;
    logic [3:0][23:0]                  pal_reg, pal_next;
    logic [dxt3_pkg::ALPHA_W-1:0]      alpha_sh_reg, alpha_sh_next;
    logic [dxt3_pkg::INDEX_W-1:0]      idx_sh_reg, idx_sh_next;
    logic [11:0]                       col4_reg, col4_next;
    logic [dxt3_pkg::PIX_IDX_W-1:0]    line_base_reg, line_base_next;

    logic                              out_free, emit, ser_done, ser_can_load;
    logic                              m_valid_reg, m_valid_next;
    logic [dxt3_pkg::M_DATA_W-1:0]     m_data_reg, m_data_next;
    logic                              m_last_reg, m_last_next;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= dxt3_pkg::RESET_WIDTH;
        end else if (cfg_valid) begin
            width_reg <= (cfg_data > dxt3_pkg::MAX_WIDTH) ? dxt3_pkg::MAX_WIDTH : cfg_data;
        end
    end

    // flow control through the stages
    assign out_free     = !m_valid_reg || m_tready;
    assign emit         = ser_v_reg && out_free;
    assign ser_done     = emit && (cnt_reg == dxt3_pkg::LAST_PIXEL);
    assign ser_can_load = !ser_v_reg || ser_done;
    assign free3        = !v3_reg || ser_can_load;
    assign free2        = !v2_reg || free3;
    assign free1        = !v1_reg || free2;
    assign s_tready     = free1;

    // stage 1: unpack fields and widen endpoints
    always_comb begin
        logic [15:0] e0, e1;
        e0 = s_tdata[79:64];
        e1 = s_tdata[95:80];
        st1_next.c0[dxt3_pkg::CH_RED]   = dxt3_pkg::widen5(e0[15:11]);
        st1_next.c0[dxt3_pkg::CH_GREEN] = dxt3_pkg::widen6(e0[10:5]);
        st1_next.c0[dxt3_pkg::CH_BLUE]  = dxt3_pkg::widen5(e0[4:0]);
        st1_next.c1[dxt3_pkg::CH_RED]   = dxt3_pkg::widen5(e1[15:11]);
        st1_next.c1[dxt3_pkg::CH_GREEN] = dxt3_pkg::widen6(e1[10:5]);
        st1_next.c1[dxt3_pkg::CH_BLUE]  = dxt3_pkg::widen5(e1[4:0]);
        st1_next.alpha_bits = s_tdata[63:0];
        st1_next.index_bits = s_tdata[127:96];
        st1_next.block_row  = s_tdata[137:128];
        st1_next.block_col  = s_tdata[147:138];
    end

    // stage 2: weighted products and row base
    always_comb begin
        logic [24:0] rb;
        for (int ch = 0; ch < 3; ch++) begin
            st2_next.near0[ch] = dxt3_pkg::weigh(dxt3_pkg::W_NEAR, st1_reg.c0[ch]);
            st2_next.far1[ch]  = dxt3_pkg::weigh(dxt3_pkg::W_FAR,  st1_reg.c1[ch]);
            st2_next.far0[ch]  = dxt3_pkg::weigh(dxt3_pkg::W_FAR,  st1_reg.c0[ch]);
            st2_next.near1[ch] = dxt3_pkg::weigh(dxt3_pkg::W_NEAR, st1_reg.c1[ch]);
        end
        rb = 25'({st1_reg.block_row, 2'b00}) * 25'(width_reg);
        st2_next.row_base   = rb[23:0];
        st2_next.c0         = st1_reg.c0;
        st2_next.c1         = st1_reg.c1;
        st2_next.alpha_bits = st1_reg.alpha_bits;
        st2_next.index_bits = st1_reg.index_bits;
        st2_next.block_col  = st1_reg.block_col;
    end

    // stage 3: sum and scale the interpolated colours
    always_comb begin
        logic [17:0] s2, s3;
        dxt3_pkg::rgb_t c2, c3;
        for (int ch = 0; ch < 3; ch++) begin
            s2 = st2_reg.near0[ch] + st2_reg.far1[ch];
            s3 = st2_reg.far0[ch] + st2_reg.near1[ch];
            c2[ch] = s2[17:10];
            c3[ch] = s3[17:10];
        end
        st3_next.palette[0] = st2_reg.c0;
        st3_next.palette[1] = st2_reg.c1;
        st3_next.palette[2] = c2;
        st3_next.palette[3] = c3;
        st3_next.row_base   = st2_reg.row_base;
        st3_next.alpha_bits = st2_reg.alpha_bits;
        st3_next.index_bits = st2_reg.index_bits;
        st3_next.block_col  = st2_reg.block_col;
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (free1) v1_reg <= s_tvalid;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (free1) st1_reg <= st1_next;
        if (free2) st2_reg <= st2_next;
        if (free3) st3_reg <= st3_next;
    end

    // pixel serializer
    always_comb begin
        ser_v_next     = ser_v_reg;
        cnt_next       = cnt_reg;
        pal_next       = pal_reg;
        alpha_sh_next  = alpha_sh_reg;
        idx_sh_next    = idx_sh_reg;
        col4_next      = col4_reg;
        line_base_next = line_base_reg;
        if (ser_can_load) begin
            ser_v_next     = v3_reg;
            cnt_next       = '0;
            pal_next       = st3_reg.palette;
            alpha_sh_next  = st3_reg.alpha_bits;
            idx_sh_next    = st3_reg.index_bits;
            col4_next      = {st3_reg.block_col, 2'b00};
            line_base_next = st3_reg.row_base;
        end else if (emit) begin
            cnt_next      = cnt_reg + 4'd1;
            alpha_sh_next = alpha_sh_reg >> 4;
            idx_sh_next   = idx_sh_reg >> 2;
            if (cnt_reg[1:0] == 2'd3) begin
                line_base_next = line_base_reg + dxt3_pkg::PIX_IDX_W'(width_reg);
            end
        end
    end

    // pixel output register
    always_comb begin
        logic [23:0]    pix_idx;
        dxt3_pkg::rgb_t col;
        logic [7:0]     a8;
        pix_idx      = line_base_reg + 24'(col4_reg) + 24'(cnt_reg[1:0]);
        col          = pal_reg[idx_sh_reg[1:0]];
        a8           = (alpha_sh_reg[3:0] == 4'd0) ? 8'h00 : 8'hFF;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = ser_v_reg;
            m_data_next  = {a8, col[dxt3_pkg::CH_BLUE], col[dxt3_pkg::CH_GREEN],
                            col[dxt3_pkg::CH_RED], pix_idx};
            m_last_next  = (cnt_reg == dxt3_pkg::LAST_PIXEL);
        end
    end

    // serializer and output control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_v_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ser_v_reg   <= ser_v_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // serializer and output payload
    always_ff @(posedge aclk) begin
        pal_reg       <= pal_next;
        alpha_sh_reg  <= alpha_sh_next;
        idx_sh_reg    <= idx_sh_next;
        col4_reg      <= col4_next;
        line_base_reg <= line_base_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
